>>> sv/msort_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Merge sorter package
// Shared constants, controller states and the command and status bundles
// that join the merge sorter controller and datapath.
// ----------------------------------------------------------------------------
package msort_pkg;

   localparam int MAX_ITEMS_DEF = 64;
   localparam int DATA_W        = 32;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_PREP,
      ST_MERGE,
      ST_EMIT
   } msort_state_type;

   typedef struct packed {
      logic load;
      logic init;
      logic merge;
      logic emit;
   } msort_cmd_type;

   typedef struct packed {
      logic sorted;
      logic pass_end;
      logic emit_end;
      logic out_free;
   } msort_sts_type;

endpackage
`default_nettype wire

>>> sv/msort_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Merge sorter controller
// Sequences loading, merge passes and emission of one set at a time.
// ----------------------------------------------------------------------------
module msort_ctrl
   import msort_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_last,
   input  wire msort_sts_type sts,
   output msort_cmd_type      cmd,
   output logic               req_stall
);

   msort_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last) state_in = ST_INIT;
         end
         ST_INIT: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = sts.sorted ? ST_EMIT : ST_MERGE;
         end
         ST_MERGE: begin
            if (sts.pass_end) state_in = ST_PREP;
         end
         ST_EMIT: begin
            if (sts.out_free && sts.emit_end) state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
         end
         ST_PREP: begin
            cmd = '0;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> sv/msort_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Merge sorter datapath
// Two ping-pong element memories, run and merge indices, the compare unit
// and the result register.
// ----------------------------------------------------------------------------
module msort_dp
   import msort_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire msort_cmd_type            cmd,
   output msort_sts_type                 sts,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_sorted_value,
   output logic                          rsp_final_res,
   output logic                          rsp_overflow
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int WW = CW + 1;
   localparam int SW = CW + 2;

   logic [DATA_W-1:0] mem0 [MAX_ITEMS];
   logic [DATA_W-1:0] mem1 [MAX_ITEMS];

   logic [DATA_W-1:0] m0a_ff, m0b_ff, m1a_ff, m1b_ff;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              drop_ff, drop_in;
   logic [WW-1:0]     w_ff, w_in;
   logic [CW-1:0]     i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CW-1:0]     mid_ff, mid_in, hi_ff, hi_in;
   logic              par_ff, par_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_final_ff, rsp_ovf_ff;

   logic [DATA_W-1:0] rd_a, rd_b, wdata;
   logic              take_l, run_end, pass_end, emit_end;
   logic [CW-1:0]     k_inc;
   logic [CW-1:0]     lo_sel;
   logic [WW-1:0]     w_sel;
   logic [SW-1:0]     lw_sum, l2w_sum;
   logic [CW-1:0]     mid_new, hi_new;
   logic              we0, we1;
   logic [AW-1:0]     wa0;
   logic [DATA_W-1:0] wd0;

   // The source of the current pass is the memory selected by par_ff.
   assign rd_a = par_ff ? m1a_ff : m0a_ff;
   assign rd_b = par_ff ? m1b_ff : m0b_ff;

   assign take_l  = (i_ff < mid_ff) &&
                    (!(j_ff < hi_ff) || ($signed(rd_a) <= $signed(rd_b)));
   assign wdata    = take_l ? rd_a : rd_b;
   assign k_inc    = k_ff + CW'(1);
   assign run_end  = (k_inc == hi_ff);
   assign pass_end = (k_inc == cnt_ff);
   assign emit_end = ((i_ff + CW'(1)) == cnt_ff);

   // Bounds of the next run: mid = min(lo + w, n), hi = min(lo + 2w, n).
   assign lo_sel  = (cmd.init || pass_end) ? '0 : hi_ff;
   assign w_sel   = cmd.init ? WW'(1) : (pass_end ? (w_ff << 1) : w_ff);
   assign lw_sum  = SW'(lo_sel) + SW'(w_sel);
   assign l2w_sum = SW'(lo_sel) + (SW'(w_sel) << 1);
   assign mid_new = (lw_sum < SW'(cnt_ff)) ? lw_sum[CW-1:0] : cnt_ff;
   assign hi_new  = (l2w_sum < SW'(cnt_ff)) ? l2w_sum[CW-1:0] : cnt_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      drop_in = drop_ff;
      w_in    = w_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      mid_in  = mid_ff;
      hi_in   = hi_ff;
      par_in  = par_ff;
      if (cmd.load) begin
         if (cnt_ff < CW'(MAX_ITEMS)) begin
            cnt_in = cnt_ff + CW'(1);
         end else begin
            drop_in = 1'b1;
         end
      end
      if (cmd.init) begin
         w_in   = WW'(1);
         par_in = 1'b0;
         i_in   = '0;
         k_in   = '0;
         j_in   = mid_new;
         mid_in = mid_new;
         hi_in  = hi_new;
      end
      if (cmd.merge) begin
         if (take_l) begin
            i_in = i_ff + CW'(1);
         end else begin
            j_in = j_ff + CW'(1);
         end
         k_in = k_inc;
         if (run_end) begin
            i_in   = lo_sel;
            k_in   = lo_sel;
            j_in   = mid_new;
            mid_in = mid_new;
            hi_in  = hi_new;
            if (pass_end) begin
               w_in   = w_sel;
               par_in = !par_ff;
            end
         end
      end
      if (cmd.emit) begin
         i_in = i_ff + CW'(1);
         if (emit_end) begin
            cnt_in  = '0;
            drop_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         drop_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      par_ff <= par_in;
   end

   // Memory 0 takes loads and the output of passes that read memory 1.
   assign we0 = cmd.load || (cmd.merge && par_ff);
   assign wa0 = cmd.load ? cnt_ff[AW-1:0] : k_ff[AW-1:0];
   assign wd0 = cmd.load ? DATA_W'(req_value) : wdata;
   assign we1 = cmd.merge && !par_ff;

   always_ff @(posedge clock) begin
      if (we0 && (!cmd.load || (cnt_ff < CW'(MAX_ITEMS)))) begin
         mem0[wa0] <= wd0;
      end
      m0a_ff <= mem0[i_in[AW-1:0]];
      m0b_ff <= mem0[j_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         mem1[k_ff[AW-1:0]] <= wdata;
      end
      m1a_ff <= mem1[i_in[AW-1:0]];
      m1b_ff <= mem1[j_in[AW-1:0]];
   end

   // Result register: loaded on emit, only when empty or its transfer completes.
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff <= rd_a;
         rsp_final_ff <= emit_end;
         rsp_ovf_ff   <= drop_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = $signed(rsp_value_ff);
   assign rsp_final_res    = rsp_final_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   assign sts.sorted   = (WW'(cnt_ff) <= w_ff);
   assign sts.pass_end = pass_end;
   assign sts.emit_end = emit_end;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

endmodule
`default_nettype wire

>>> sv/merge_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Merge sorter
// Collects a set of signed 32-bit values and returns it in ascending order.
// ----------------------------------------------------------------------------
// Values are taken one per cycle until a transfer with req_last high closes
// the set; at most MAX_ITEMS values are kept and any further ones are dropped,
// which raises rsp_overflow on every result of that set. The set of n values
// is then sorted by bottom-up merge passes that ping-pong between two element
// memories: ceil(log2(n)) passes, each followed by a re-read in state PREP,
// with the INIT and PREP setup states before the first, because the single merge unit
// compares two run heads and writes one element per cycle. Results then leave
// one per cycle while the receiver does not stall, through an output register,
// with rsp_final_res on the last. New input is accepted as soon as the last
// result sits in the output register.
// ----------------------------------------------------------------------------
module merge_sorter
   import msort_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     req_last,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_sorted_value,
   output logic                          rsp_final_res,
   output logic                          rsp_overflow
);

   msort_cmd_type cmd;
   msort_sts_type sts;

   msort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   msort_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res),
      .rsp_overflow     (rsp_overflow)
   );

`ifndef ASSERT_OFF
   // A stalled result keeps its payload until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sorted_value) &&
         $stable(rsp_final_res) && $stable(rsp_overflow)))
      else $error("stalled result changed before its transfer");

   // While input is open, only the final result of the previous set may wait.
   assert property (@(posedge clock) disable iff (reset)
      (!req_stall && rsp_valid) |-> rsp_final_res)
      else $error("input open while a set is still being emitted");

   // The block leaves the loading phase only after a transfer that closes a set.
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && req_last))
      else $error("sorting started without a closing transfer");
`endif

endmodule
`default_nettype wire

>>> tb/tb_merge_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Merge sorter testbench
// Loads sets of signed values through the request channel and checks that
// every set comes back in ascending order, with the final flag on its last
// element and the overflow flag on every element of a set that lost values.
// Both channels idle and stall at random. Two stretches run without idling,
// and in the second a long receiver hold-off makes the block back up into its input.
// ----------------------------------------------------------------------------
module tb_merge_sorter;
   import msort_pkg::*;

   localparam int CAPACITY    = MAX_ITEMS_DEF;
   localparam int HOLD_CYCLES = 500;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     final_res;
      logic                     overflow;
   } sorted_item_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_value;
   logic                     req_last;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_sorted_value;
   logic                     rsp_final_res;
   logic                     rsp_overflow;

   // Values of the set being loaded, as the block is expected to hold them.
   logic signed [DATA_W-1:0] held_values[$];
   logic                     set_dropped;
   sorted_item_type          expected_sorted[$];

   int                       mismatch_count = 0;
   int                       hold_cycles = 0;
   bit                       hold_taken = 1'b0;
   bit                       hold_req;
   bit                       steady;

   merge_sorter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res),
      .rsp_overflow     (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Sorts the closed set and queues one expected result per held value.
   function automatic void close_set();
      logic signed [DATA_W-1:0] vals[$];
      logic signed [DATA_W-1:0] key;
      int                       j;
      sorted_item_type          item;
      vals = held_values;
      for (int i = 1; i < vals.size(); i++) begin
         key = vals[i];
         j = i - 1;
         while (j >= 0 && vals[j] > key) begin
            vals[j + 1] = vals[j];
            j--;
         end
         vals[j + 1] = key;
      end
      for (int i = 0; i < vals.size(); i++) begin
         item.value     = vals[i];
         item.final_res = (i == vals.size() - 1);
         item.overflow  = set_dropped;
         expected_sorted = {expected_sorted, item};
      end
      held_values.delete();
      set_dropped = 1'b0;
   endfunction

   function automatic void take_value(input logic signed [DATA_W-1:0] v, input logic l);
      if (held_values.size() < CAPACITY)
         held_values = {held_values, v};
      else
         set_dropped = 1'b1;
      if (l)
         close_set();
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(9))
         5, 6: v = $signed(int'($urandom_range(8)) - 4);
         7: begin
            case ($urandom_range(3))
               0: v = 32'sh8000_0000;
               1: v = 32'sh7fff_ffff;
               2: v = '0;
               default: v = '1;
            endcase
         end
         8, 9: v = $signed(int'($urandom_range(1000)) - 500);
         default: v = $signed($urandom());
      endcase
      return v;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s", $realtime, msg);
   endtask

   // Offers one item and returns at the edge where it is transferred.
   task automatic send_item(input logic signed [DATA_W-1:0] v, input logic l);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= l;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      take_value(v, l);
   endtask

   task automatic send_set(input int n);
      for (int i = 0; i < n; i++)
         send_item(pick_value(), i == n - 1);
   endtask

   task automatic send_list(input logic signed [DATA_W-1:0] vals[$]);
      foreach (vals[i])
         send_item(vals[i], i == vals.size() - 1);
   endtask

   task automatic test_directed();
      send_list('{32'sh8000_0000});
      send_list('{32'sh7fff_ffff, 32'sh8000_0000});
      send_list('{0, -1, 1, 32'sh7fff_ffff, 32'sh8000_0000, 0});
      send_list('{-3, -2, -1});
      send_list('{5, 4, 3, 2});
      send_list('{32'shaaaa_aaaa, 32'sh5555_5555});
   endtask

   // A full store, then a set that overruns it and has its closing value dropped.
   task automatic test_capacity();
      send_set(CAPACITY);
      send_set(CAPACITY + 2);
   endtask

   task automatic test_random_sets();
      int sent;
      int n;
      int r;
      sent = 0;
      while (sent < 125) begin
         r = $urandom_range(99);
         if (r < 70)
            n = $urandom_range(10, 1);
         else if (r < 85)
            n = $urandom_range(40, 11);
         else if (r < 95)
            n = $urandom_range(CAPACITY, CAPACITY - 9);
         else
            n = $urandom_range(CAPACITY + 8, CAPACITY + 1);
         send_set(n);
         sent += n;
      end
   endtask

   task automatic test_steady_stream();
      steady = 1'b1;
      send_set(1);
      send_set(2);
      send_set(17);
      send_set(20);
      steady = 1'b0;
   endtask

   // The receiver holds off long enough for the block to back up into its input.
   task automatic test_backpressure();
      steady   = 1'b1;
      hold_req = 1'b1;
      send_set(30);
      send_set(30);
      steady = 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken  = 1'b1;
         hold_cycles = HOLD_CYCLES;
      end
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 23);
      end
   end

   always @(posedge clock) begin
      sorted_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sorted.size() == 0) begin
            flag_mismatch($sformatf("unexpected result %0d final %0b overflow %0b",
                                    rsp_sorted_value, rsp_final_res, rsp_overflow));
         end else begin
            want = expected_sorted.pop_front();
            if (rsp_sorted_value !== want.value)
               flag_mismatch($sformatf("sorted_value expected %0d got %0d",
                                       want.value, rsp_sorted_value));
            if (rsp_final_res !== want.final_res)
               flag_mismatch($sformatf("final_res expected %0b got %0b",
                                       want.final_res, rsp_final_res));
            if (rsp_overflow !== want.overflow)
               flag_mismatch($sformatf("overflow expected %0b got %0b",
                                       want.overflow, rsp_overflow));
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_value   = '0;
      req_last    = 1'b0;
      set_dropped = 1'b0;
      hold_req    = 1'b0;
      steady      = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_capacity();
      test_random_sets();
      test_steady_stream();
      test_backpressure();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_sorted.size() != 0)
         @(posedge clock);
      // Give stray results time to show.
      repeat (700) @(posedge clock);
      if (mismatch_count == 0 && expected_sorted.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
